// ===== rtl/dq_pkg.sv =====
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WORK = 1'b1
  } state_t;

endpackage

// ===== rtl/dq_ram.sv =====
// Ring store of queue words: one write port, one read port with registered data.
`timescale 1ns / 1ps
module dq_ram #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 6
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// Top level of the bounded double-ended queue with ring store and end-word registers.
//
//   channel   ports                                   transfer
//   input     start, busy, in_op, in_push_value       start high while busy low
//   result    out_valid, out_* fields                 out_valid high, one cycle
//
// The accept cycle of an operation updates the indices, the count
// and the store, and issues the one store read a pop needs to refill the end word
// that moves inward; the following cycle takes the read data and registers the
// result, which shows on the next cycle with out_valid. busy is high for one cycle
// after each transfer, so no operation is accepted while the last one is being worked.
// Reset is synchronous and clears indices, count and control; the store needs no
// clearing since only words that were pushed are ever read. The receiver cannot
// stall, so a result never waits.
`timescale 1ns / 1ps
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_op,
  input  logic [DATA_WIDTH-1:0]           in_push_value,
  output logic                            out_valid,
  output logic [DATA_WIDTH-1:0]           out_popped_value,
  output logic [DATA_WIDTH-1:0]           out_front_value,
  output logic [DATA_WIDTH-1:0]           out_back_value,
  output logic [$clog2(DEPTH+1)-1:0]      out_entry_count,
  output logic                            out_is_empty,
  output logic [1:0]                      out_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] i);
    step_up = (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] i);
    step_down = (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  state_t state_r, state_nxt;

  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] front_r, front_nxt;
  logic [DATA_WIDTH-1:0] back_r, back_nxt;

  // Pending operation held from the accept cycle into the work cycle.
  logic [DATA_WIDTH-1:0] pend_popped_r, pend_popped_nxt;
  status_t               pend_status_r, pend_status_nxt;
  logic                  pend_refill_r, pend_refill_nxt;
  logic                  pend_front_r, pend_front_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_popped_r, out_front_r, out_back_r;
  logic [CW-1:0]         out_count_r;
  logic                  out_empty_r;
  status_t               out_status_r;

  logic                  accept;
  logic                  full;
  logic                  empty;
  op_t                   op_w;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  dq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign op_w   = op_t'(in_op);
  assign full   = (count_r == FULL_CNT);
  assign empty  = (count_r == '0);
  assign accept = start && (state_r == S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_WORK;
      S_WORK: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    busy          = (state_r == S_WORK);
    out_valid_nxt = (state_r == S_WORK);
  end

  // Datapath: index, count, store and pushed end-word updates at accept, pop refill after.
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    front_nxt       = front_r;
    back_nxt        = back_r;
    pend_popped_nxt = pend_popped_r;
    pend_status_nxt = pend_status_r;
    pend_refill_nxt = pend_refill_r;
    pend_front_nxt  = pend_front_r;
    wr_en           = 1'b0;
    wr_addr         = step_down(head_r);
    rd_en           = 1'b0;
    rd_addr         = step_up(head_r);

    if (accept) begin
      pend_popped_nxt = '0;
      pend_status_nxt = ST_OK;
      pend_refill_nxt = 1'b0;
      pend_front_nxt  = 1'b0;
      unique case (op_w)
        OP_PUSH_FRONT: begin
          if (full) begin
            pend_status_nxt = ST_OVERFLOW;
          end else begin
            head_nxt  = step_down(head_r);
            wr_en     = 1'b1;
            wr_addr   = step_down(head_r);
            front_nxt = in_push_value;
            if (empty) back_nxt = in_push_value;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            pend_status_nxt = ST_OVERFLOW;
          end else begin
            tail_nxt = step_up(tail_r);
            wr_en    = 1'b1;
            wr_addr  = tail_r;
            back_nxt = in_push_value;
            if (empty) front_nxt = in_push_value;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            pend_status_nxt = ST_UNDERFLOW;
          end else begin
            pend_popped_nxt = front_r;
            head_nxt        = step_up(head_r);
            rd_en           = 1'b1;
            rd_addr         = step_up(head_r);
            count_nxt       = count_r - CW'(1);
            pend_refill_nxt = (count_r != CW'(1));
            pend_front_nxt  = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            pend_status_nxt = ST_UNDERFLOW;
          end else begin
            pend_popped_nxt = back_r;
            tail_nxt        = step_down(tail_r);
            rd_en           = 1'b1;
            rd_addr         = step_down(step_down(tail_r));
            count_nxt       = count_r - CW'(1);
            pend_refill_nxt = (count_r != CW'(1));
            pend_front_nxt  = 1'b0;
          end
        end
        default: pend_status_nxt = ST_OK;
      endcase
    end else if (state_r == S_WORK && pend_refill_r) begin
      if (pend_front_r) begin
        front_nxt = rd_data;
      end else begin
        back_nxt = rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r       <= front_nxt;
    back_r        <= back_nxt;
    pend_popped_r <= pend_popped_nxt;
    pend_status_r <= pend_status_nxt;
    pend_refill_r <= pend_refill_nxt;
    pend_front_r  <= pend_front_nxt;
    if (state_r == S_WORK) begin
      out_popped_r <= pend_popped_r;
      out_front_r  <= empty ? '0 : front_nxt;
      out_back_r   <= empty ? '0 : back_nxt;
      out_count_r  <= count_r;
      out_empty_r  <= empty;
      out_status_r <= pend_status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_front_value  = out_front_r;
  assign out_back_value   = out_back_r;
  assign out_entry_count  = out_count_r;
  assign out_is_empty     = out_empty_r;
  assign out_status       = out_status_r;

endmodule

// ===== sim/double_ended_queue_checker.sv =====
// Checker that predicts and compares every result of the double-ended queue.
`timescale 1ns / 1ps
module double_ended_queue_checker
  import dq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [1:0]                      in_op,
  input  logic [DATA_WIDTH-1:0]           in_push_value,
  input  logic                            out_valid,
  input  logic [DATA_WIDTH-1:0]           out_popped_value,
  input  logic [DATA_WIDTH-1:0]           out_front_value,
  input  logic [DATA_WIDTH-1:0]           out_back_value,
  input  logic [$clog2(DEPTH+1)-1:0]      out_entry_count,
  input  logic                            out_is_empty,
  input  logic [1:0]                      out_status,
  output int                              mismatches,
  output int                              outstanding
);

  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    logic [DATA_WIDTH-1:0]  popped;
    logic [DATA_WIDTH-1:0]  front;
    logic [DATA_WIDTH-1:0]  back;
    logic [COUNT_WIDTH-1:0] count;
    logic                   empty;
    status_t                status;
  } dq_result_t;

  logic [DATA_WIDTH-1:0] slot_words [DEPTH];
  int unsigned           head_slot;
  int unsigned           tail_slot;
  int unsigned           word_count;
  dq_result_t            pending_results [$];

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic int unsigned slot_below(input int unsigned idx);
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  function automatic int unsigned slot_above(input int unsigned idx);
    return (idx + 1 >= DEPTH) ? 0 : idx + 1;
  endfunction

  // Applies one operation to the shadow queue and returns the result it should produce.
  function automatic dq_result_t apply_queue_op(input op_t op,
                                                input logic [DATA_WIDTH-1:0] value);
    dq_result_t r;
    r.popped = '0;
    r.front  = '0;
    r.back   = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (word_count >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else if (op == OP_PUSH_FRONT) begin
          head_slot = slot_below(head_slot);
          slot_words[head_slot] = value;
          word_count++;
        end else begin
          slot_words[tail_slot] = value;
          tail_slot = slot_above(tail_slot);
          word_count++;
        end
      end
      default: begin
        if (word_count == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (op == OP_POP_FRONT) begin
          r.popped = slot_words[head_slot];
          head_slot = slot_above(head_slot);
          word_count--;
        end else begin
          tail_slot = slot_below(tail_slot);
          r.popped = slot_words[tail_slot];
          word_count--;
        end
      end
    endcase
    if (word_count != 0) begin
      r.front = slot_words[head_slot];
      r.back  = slot_words[slot_below(tail_slot)];
    end
    r.count = word_count[COUNT_WIDTH-1:0];
    r.empty = (word_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    dq_result_t want;
    if (!rst_n) begin
      head_slot  = 0;
      tail_slot  = 0;
      word_count = 0;
      pending_results.delete();
    end else begin
      // Results are registered, so a result never belongs to the transfer at the same edge.
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no operation waiting for it");
        end else begin
          want = pending_results.pop_front();
          if (out_popped_value !== want.popped)
            report_mismatch($sformatf("popped_value %h, expected %h",
                                      out_popped_value, want.popped));
          if (out_front_value !== want.front)
            report_mismatch($sformatf("front_value %h, expected %h",
                                      out_front_value, want.front));
          if (out_back_value !== want.back)
            report_mismatch($sformatf("back_value %h, expected %h",
                                      out_back_value, want.back));
          if (out_entry_count !== want.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      out_entry_count, want.count));
          if (out_is_empty !== want.empty)
            report_mismatch($sformatf("is_empty %b, expected %b",
                                      out_is_empty, want.empty));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %s",
                                      out_status, want.status.name()));
        end
      end else if ($isunknown(out_valid)) begin
        report_mismatch("out_valid is unknown");
      end
      if (start === 1'b1 && busy === 1'b0) begin
        pending_results.push_back(apply_queue_op(op_t'(in_op), in_push_value));
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ===== sim/double_ended_queue_core_test.sv =====
// Testbench top: drives operations into the double-ended queue and reports the verdict.
`timescale 1ns / 1ps
module double_ended_queue_core_test;
  import dq_pkg::*;

  localparam int DEPTH        = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int COUNT_WIDTH  = $clog2(DEPTH + 1);
  localparam int RUN_ITEMS    = 1500;
  localparam int PHASE_ITEMS  = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum int {
    LOAD_FILL,
    LOAD_MIXED,
    LOAD_DRAIN
  } load_phase_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [1:0]             in_op;
  logic [DATA_WIDTH-1:0]  in_push_value;
  logic                   out_valid;
  logic [DATA_WIDTH-1:0]  out_popped_value;
  logic [DATA_WIDTH-1:0]  out_front_value;
  logic [DATA_WIDTH-1:0]  out_back_value;
  logic [COUNT_WIDTH-1:0] out_entry_count;
  logic                   out_is_empty;
  logic [1:0]             out_status;
  int                     mismatches;
  int                     outstanding;
  int                     cycle_count;

  double_ended_queue_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_status       (out_status)
  );

  double_ended_queue_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) checker_inst (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_status       (out_status),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Holds the operation on the inputs until the block takes it.
  task automatic issue_op(input op_t op, input logic [DATA_WIDTH-1:0] value);
    @(negedge clk);
    start         = 1'b1;
    in_op         = op;
    in_push_value = value;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic op_t pick_op(input load_phase_t phase);
    int push_pct;
    push_pct = (phase == LOAD_FILL) ? 85 : (phase == LOAD_DRAIN) ? 15 : 50;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          sent;
    int          burst_len;
    load_phase_t phase;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_op         = OP_PUSH_FRONT;
    in_push_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: underflow on both ends, extreme words, wrap of both indices.
    issue_op(OP_POP_FRONT, 32'h1234_5678);
    issue_op(OP_POP_BACK, '1);
    issue_op(OP_PUSH_FRONT, '1);
    issue_op(OP_PUSH_FRONT, '0);
    pause_sender(2);
    issue_op(OP_PUSH_BACK, 32'h8000_0001);
    issue_op(OP_POP_BACK, '0);
    issue_op(OP_POP_BACK, '1);
    pause_sender(1);
    issue_op(OP_POP_BACK, 32'h5555_5555);
    issue_op(OP_POP_FRONT, '0);
    issue_op(OP_PUSH_BACK, 32'hA5A5_A5A5);
    issue_op(OP_POP_FRONT, '1);
    issue_op(OP_PUSH_BACK, 32'h0000_0001);
    issue_op(OP_PUSH_FRONT, 32'hFFFF_FFFE);
    pause_sender(3);
    issue_op(OP_POP_FRONT, '0);
    issue_op(OP_POP_BACK, '0);
    issue_op(OP_POP_FRONT, '0);

    // Random: phases that push hard, mix, and pop hard, so the queue runs full and empty.
    sent = 0;
    while (sent < RUN_ITEMS) begin
      case ((sent / PHASE_ITEMS) % 4)
        0:       phase = LOAD_FILL;
        2:       phase = LOAD_DRAIN;
        default: phase = LOAD_MIXED;
      endcase
      burst_len = $urandom_range(1, 24);
      repeat (burst_len) begin
        issue_op(pick_op(phase), pick_word());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end

    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/double_ended_queue_core.sv
sim/double_ended_queue_checker.sv
sim/double_ended_queue_core_test.sv
